/* src/alid_pkg.sv */
// Shared types and constants of the array list insert/delete unit.
`timescale 1ns / 1ps

package alid_pkg;

  localparam int unsigned DEPTH_DEF      = 128;
  localparam int unsigned WORD_WIDTH_DEF = 32;

  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_GET    = 3'd1,
    OP_LOCATE = 3'd2,
    OP_INSERT = 3'd3,
    OP_DELETE = 3'd4
  } op_e;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [7:0]         position;
    logic signed [31:0] element_value;
  } alid_in_t;

  typedef struct packed {
    logic               success;
    logic signed [31:0] read_value;
    logic [7:0]         found_position;
    logic [7:0]         list_length;
  } alid_out_t;

  // Microprogram step addresses.
  typedef enum logic [3:0] {
    S_IDLE      = 4'd0,
    S_CLR       = 4'd1,
    S_GET       = 4'd2,
    S_LOC       = 4'd3,
    S_SHIFT_UP  = 4'd4,
    S_PUT       = 4'd5,
    S_DEL_GRAB  = 4'd6,
    S_DEL_SHIFT = 4'd7,
    S_DEL_END   = 4'd8,
    S_DONE      = 4'd9
  } step_e;

  typedef enum logic [1:0] {
    PTR_HOLD = 2'd0,
    PTR_INC  = 2'd1,
    PTR_DEC  = 2'd2
  } ptr_op_e;

  typedef enum logic [1:0] {
    WR_NONE = 2'd0,
    WR_UP   = 2'd1,   // mem[ptr+1] <= read word
    WR_DOWN = 2'd2,   // mem[ptr-1] <= read word
    WR_PUT  = 2'd3    // mem[pos-1] <= request value
  } wr_mode_e;

  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_INC  = 2'd1,
    CNT_DEC  = 2'd2,
    CNT_CLR  = 2'd3
  } cnt_op_e;

  typedef enum logic [2:0] {
    J_NEXT    = 3'd0,
    J_ALWAYS  = 3'd1,
    J_TOP     = 3'd2,
    J_POS     = 3'd3,
    J_HIT_TOP = 3'd4
  } jmp_e;

  // One control word of the microprogram.
  typedef struct packed {
    ptr_op_e  ptr_op;
    wr_mode_e wr_mode;
    cnt_op_e  cnt_op;
    logic     cap_rd;
    logic     cap_found;
    jmp_e     jmp;
    step_e    tgt;
    logic     loop;
    logic     done;
  } ctrl_t;

  // Datapath status seen by the sequencer.
  typedef struct packed {
    logic hit;      // read word equals request value
    logic at_top;   // pointer sits on the last entry
    logic at_pos;   // pointer sits on the request position
  } stat_t;

endpackage

/* src/alid_useq.sv */
// Microcode sequencer: step counter, control store and jump logic.
`timescale 1ns / 1ps

module alid_useq
  import alid_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  step_e entry_i,
  input  stat_t stat_i,
  input  logic  out_busy_i,
  output ctrl_t ctrl_o,
  output logic  adv_o,
  output logic  idle_o
);

  step_e upc_q, upc_d;
  ctrl_t cw;
  logic  take;

  function automatic ctrl_t ucode(step_e s);
    ctrl_t w;
    w = '0;
    unique case (s)
      S_IDLE: begin
        w.loop = 1'b1;
      end
      S_CLR: begin
        w.cnt_op = CNT_CLR;
        w.jmp    = J_ALWAYS;
        w.tgt    = S_DONE;
      end
      S_GET: begin
        w.cap_rd = 1'b1;
        w.jmp    = J_ALWAYS;
        w.tgt    = S_DONE;
      end
      S_LOC: begin
        w.cap_found = 1'b1;
        w.ptr_op    = PTR_INC;
        w.jmp       = J_HIT_TOP;
        w.tgt       = S_DONE;
        w.loop      = 1'b1;
      end
      S_SHIFT_UP: begin
        w.wr_mode = WR_UP;
        w.ptr_op  = PTR_DEC;
        w.jmp     = J_POS;
        w.tgt     = S_PUT;
        w.loop    = 1'b1;
      end
      S_PUT: begin
        w.wr_mode = WR_PUT;
        w.cnt_op  = CNT_INC;
        w.jmp     = J_ALWAYS;
        w.tgt     = S_DONE;
      end
      S_DEL_GRAB: begin
        w.cap_rd = 1'b1;
        w.ptr_op = PTR_INC;
        w.jmp    = J_TOP;
        w.tgt    = S_DEL_END;
      end
      S_DEL_SHIFT: begin
        w.wr_mode = WR_DOWN;
        w.ptr_op  = PTR_INC;
        w.jmp     = J_TOP;
        w.tgt     = S_DEL_END;
        w.loop    = 1'b1;
      end
      S_DEL_END: begin
        w.cnt_op = CNT_DEC;
        w.jmp    = J_ALWAYS;
        w.tgt    = S_DONE;
      end
      S_DONE: begin
        w.done = 1'b1;
      end
      default: begin
        w.jmp = J_ALWAYS;
        w.tgt = S_IDLE;
      end
    endcase
    return w;
  endfunction

  assign cw     = ucode(upc_q);
  assign ctrl_o = cw;
  assign idle_o = (upc_q == S_IDLE);
  assign adv_o  = !(cw.done && out_busy_i);

  always_comb begin
    unique case (cw.jmp)
      J_NEXT:    take = 1'b0;
      J_ALWAYS:  take = 1'b1;
      J_TOP:     take = stat_i.at_top;
      J_POS:     take = stat_i.at_pos;
      J_HIT_TOP: take = stat_i.hit || stat_i.at_top;
      default:   take = 1'b1;
    endcase
  end

  always_comb begin
    priority if (upc_q == S_IDLE) begin
      upc_d = start_i ? entry_i : S_IDLE;
    end else if (cw.done) begin
      upc_d = adv_o ? S_IDLE : upc_q;
    end else if (take) begin
      upc_d = cw.tgt;
    end else if (cw.loop) begin
      upc_d = upc_q;
    end else begin
      upc_d = step_e'(upc_q + 4'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= S_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

/* src/array_list_insert_delete_unit.sv */
// Top level of the array list insert/delete unit: datapath, list store, result register.
`timescale 1ns / 1ps

// Ordered list of signed words kept in a DEPTH-entry store plus a length count.
// Input channel (in_valid_i/in_ready_o/in_data_i): one beat is one request
// (clear, get, locate, insert, delete). Output channel (out_valid_o/out_ready_i/
// out_data_o): one beat per request with success flag, read word, locate hit
// position and the list length after the request.
// A microcoded sequencer runs one request at a time; in_ready_o is high only
// while it sits in its idle step. A refused request or unknown opcode, or a
// locate on an empty list, goes straight to the done step; clear zeroes the
// length; get captures the addressed entry; locate compares entries from the
// first to the first hit or the last entry; insert moves the entries from the
// position on up one place, then writes the value; delete captures the entry,
// moves the entries above it down one place, then shortens the length. The
// sequencer is idle again once the result is registered. The single store
// port pair (one read, one write per cycle) moves or compares one entry per cycle.
// Results sit in an output register: a stalled receiver does not block the
// next accept; only the final step of the following request waits for it.
// Reset clears the length, the sequencer and the output valid. The store
// itself is not cleared; only entries below the length are ever used.

module array_list_insert_delete_unit
  import alid_pkg::*;
#(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  alid_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output alid_out_t out_data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (CW > 8) ? CW : 8;

  // list store
  logic [WORD_WIDTH-1:0] mem [DEPTH];
  logic [WORD_WIDTH-1:0] rd_q;

  // datapath registers
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [AW-1:0]         ptr_q, ptr_d;
  logic [7:0]            pos_q;
  logic [WORD_WIDTH-1:0] val_q;
  logic                  ok_q;
  logic [31:0]           rdv_q;
  logic [7:0]            found_q;

  alid_out_t out_q;
  logic      out_valid_q;

  // sequencer link
  ctrl_t cw;
  stat_t stat;
  logic  adv, idle, in_fire, finish;
  step_e entry;

  // decode of the incoming request
  logic                  pos_ok, ins_ok, ok_in;
  logic [XW-1:0]         pos_x, cnt_x, pos_m1, posq_m1;
  logic [CW-1:0]         cnt_m1;
  logic [AW-1:0]         ptr_init;
  logic signed [63:0]    val_ext;
  logic [WORD_WIDTH-1:0] val_in;
  logic signed [WORD_WIDTH-1:0] rd_s;
  logic signed [63:0]    rd_ext;

  // write port
  logic                  wr_en;
  logic [AW-1:0]         wa;
  logic [WORD_WIDTH-1:0] wd;

  assign in_ready_o  = idle;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign finish      = cw.done && adv;

  assign val_ext = 64'(in_data_i.element_value);
  assign val_in  = val_ext[WORD_WIDTH-1:0];
  assign rd_s    = rd_q;
  assign rd_ext  = 64'(rd_s);

  assign pos_x   = XW'(in_data_i.position);
  assign cnt_x   = XW'(cnt_q);
  assign pos_m1  = pos_x - XW'(1);
  assign cnt_m1  = cnt_q - CW'(1);
  assign posq_m1 = XW'(pos_q) - XW'(1);
  assign pos_ok  = (pos_x != '0) && (pos_x <= cnt_x);
  assign ins_ok  = (pos_x != '0) && (pos_x <= cnt_x + XW'(1)) && (cnt_q != CW'(DEPTH));

  // entry step, success flag and starting pointer per opcode
  always_comb begin
    entry    = S_DONE;
    ok_in    = 1'b0;
    ptr_init = '0;
    unique case (op_e'(in_data_i.opcode))
      OP_CLEAR: begin
        entry = S_CLR;
        ok_in = 1'b1;
      end
      OP_GET: begin
        ok_in    = pos_ok;
        entry    = pos_ok ? S_GET : S_DONE;
        ptr_init = pos_m1[AW-1:0];
      end
      OP_LOCATE: begin
        ok_in = 1'b1;
        entry = (cnt_q == '0) ? S_DONE : S_LOC;
      end
      OP_INSERT: begin
        ok_in    = ins_ok;
        ptr_init = cnt_m1[AW-1:0];
        if (!ins_ok) begin
          entry = S_DONE;
        end else if (pos_x == cnt_x + XW'(1)) begin
          entry = S_PUT;  // tail insert, nothing to move
        end else begin
          entry = S_SHIFT_UP;
        end
      end
      OP_DELETE: begin
        ok_in    = pos_ok;
        entry    = pos_ok ? S_DEL_GRAB : S_DONE;
        ptr_init = pos_m1[AW-1:0];
      end
      default: begin
        entry = S_DONE;
      end
    endcase
  end

  // status back to the sequencer
  assign stat.hit    = (rd_q == val_q);
  assign stat.at_top = (CW'(ptr_q) == cnt_m1);
  assign stat.at_pos = (XW'(ptr_q) == posq_m1);

  alid_useq u_useq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_fire),
    .entry_i    (entry),
    .stat_i     (stat),
    .out_busy_i (out_valid_q && !out_ready_i),
    .ctrl_o     (cw),
    .adv_o      (adv),
    .idle_o     (idle)
  );

  // pointer: loaded on accept, stepped by the microword
  always_comb begin
    ptr_d = ptr_q;
    if (in_fire) begin
      ptr_d = ptr_init;
    end else if (adv) begin
      unique case (cw.ptr_op)
        PTR_INC:  ptr_d = ptr_q + AW'(1);
        PTR_DEC:  ptr_d = ptr_q - AW'(1);
        default:  ptr_d = ptr_q;
      endcase
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (adv) begin
      unique case (cw.cnt_op)
        CNT_INC:  cnt_d = cnt_q + CW'(1);
        CNT_DEC:  cnt_d = cnt_q - CW'(1);
        CNT_CLR:  cnt_d = '0;
        default:  cnt_d = cnt_q;
      endcase
    end
  end

  always_comb begin
    wr_en = adv && (cw.wr_mode != WR_NONE);
    wa    = ptr_q;
    wd    = rd_q;
    unique case (cw.wr_mode)
      WR_UP:   wa = ptr_q + AW'(1);
      WR_DOWN: wa = ptr_q - AW'(1);
      WR_PUT: begin
        wa = posq_m1[AW-1:0];
        wd = val_q;
      end
      default: wa = ptr_q;
    endcase
  end

  // store: one write and one registered read per cycle; read follows ptr_d
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[ptr_d];
  end

  // request operands and result fields
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pos_q   <= in_data_i.position;
      val_q   <= val_in;
      ok_q    <= ok_in;
      rdv_q   <= '0;
      found_q <= '0;
    end else begin
      if (cw.cap_rd) begin
        rdv_q <= rd_ext[31:0];
      end
      if (cw.cap_found && stat.hit) begin
        found_q <= 8'(CW'(ptr_q) + CW'(1));
      end
    end
    if (finish) begin
      out_q.success        <= ok_q;
      out_q.read_value     <= rdv_q;
      out_q.found_position <= found_q;
      out_q.list_length    <= 8'(cnt_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      ptr_q <= ptr_d;
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // length never runs past the store
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("list length above store depth");

  // writes stay at or below the current length
  a_wr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (CW'(wa) <= cnt_q))
    else $error("store write beyond list end");

  // an accepted beat closes the input as the program leaves its idle step
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("input reopened during a running request");

  // a stalled result is never overwritten by the next request
  a_no_clobber: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !finish)
    else $error("result register overwritten while stalled");

endmodule
